>>> hdl/rational_accumulator_reduce_top_defines.svh
// Assertion macros for the rational accumulator.
// Used by rational_accumulator_reduce_top; depends on nothing.
`ifndef RATIONAL_ACCUMULATOR_REDUCE_TOP_DEFINES_SVH
`define RATIONAL_ACCUMULATOR_REDUCE_TOP_DEFINES_SVH
// Assert that a condition implies a consequence in the same cycle.
`define RAR_ASSERT_IMP(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
// Assert that a condition implies a consequence in the next cycle.
`define RAR_ASSERT_NXT(lbl, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`endif

>>> hdl/rar_pkg.sv
// Package for the rational accumulator: widths, op codes, sequencer states.
// No dependencies.
package rar_pkg;
    localparam int DataWidth = 32;
    localparam int CntWidth  = $clog2(DataWidth + 1);

    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4
    } op_t;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_MUL1  = 9'b000000010,
        ST_MUL2  = 9'b000000100,
        ST_MUL3  = 9'b000001000,
        ST_CHECK = 9'b000010000,
        ST_GCD   = 9'b000100000,
        ST_DIVN  = 9'b001000000,
        ST_DIVD  = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;
endpackage

>>> hdl/rational_accumulator_reduce_top.sv
// Rational accumulator with gcd reduction, top level.
// Uses rar_pkg and rational_accumulator_reduce_top_defines.svh.
//
// Input channel in_valid/in_ready carries op, operand_num, operand_den.
// Output channel out_valid/out_ready carries result_num, result_den.
// One word in gives one word out. The block takes one word at a time:
// in_ready is high only when no word is in work and the output is empty.
// Products run through ST_MUL1, ST_MUL2 and, for add and subtract, ST_MUL3 on one shared 32x32 multiplier.
// Reduction runs Euclid's gcd as bit-serial restoring division on one
// shared subtractor, one DataWidth-bit division per modulo step (up to
// about 47 remainders), then two more bit-serial divisions by the gcd
// scale numerator and denominator.
// An unknown op goes straight to the output state; a zero result skips reduction.
// Reset sets the accumulator to 1/1 and empties the output register.
// When out_ready is low the result holds in the output register and no new
// word is taken until it leaves.
`include "rational_accumulator_reduce_top_defines.svh"
module rational_accumulator_reduce_top
    import rar_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           op,
    input  logic signed [31:0]   operand_num,
    input  logic signed [31:0]   operand_den,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [31:0]   result_num,
    output logic signed [31:0]   result_den
);
    localparam int W = DataWidth;

    state_t              state_reg, state_next;
    logic [W-1:0]        acc_num_reg, acc_num_next, acc_den_reg, acc_den_next;
    logic [W-1:0]        n_reg, n_next, d_reg, d_next;
    logic [2:0]          op_reg, op_next;
    logic [W-1:0]        t_reg, t_next;
    logic [W-1:0]        a_reg, a_next, b_reg, b_next;
    logic [W-1:0]        q_reg, q_next, r_reg, r_next;
    logic [CntWidth-1:0] cnt_reg, cnt_next;
    logic                phase_reg, phase_next;
    logic                out_valid_reg, out_valid_next;
    logic [31:0]         rnum_reg, rnum_next, rden_reg, rden_next;

    logic [W-1:0]        mul_a, mul_b, mul_p;
    logic [W-1:0]        div_d, r_sh, mag_num, mag_den;
    logic [W:0]          r_sub;
    logic [W-1:0]        num_in, den_in;

    function automatic logic [W-1:0] mag(input logic [W-1:0] x);
        return x[W-1] ? (~x + 1'b1) : x;
    endfunction

    assign num_in  = W'(operand_num);
    assign den_in  = W'(operand_den);
    assign mul_p   = mul_a * mul_b;
    assign mag_num = mag(acc_num_reg);
    assign mag_den = mag(acc_den_reg);
    assign r_sh    = {r_reg[W-2:0], q_reg[W-1]};
    assign r_sub   = {r_reg, q_reg[W-1]} - {1'b0, div_d};

    assign in_ready   = (state_reg == ST_IDLE) && !out_valid_reg;
    assign out_valid  = out_valid_reg;
    assign result_num = rnum_reg;
    assign result_den = rden_reg;

    always_comb
    begin
        mul_a = acc_num_reg;
        mul_b = d_reg;
        case (state_reg)
            ST_MUL1: begin mul_a = acc_num_reg; mul_b = d_reg; end
            ST_MUL2: begin mul_a = acc_den_reg; mul_b = n_reg; end
            ST_MUL3: begin mul_a = acc_den_reg; mul_b = d_reg; end
            default: begin mul_a = acc_num_reg; mul_b = d_reg; end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            ST_GCD:  div_d = b_reg;
            default: div_d = a_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        acc_num_next   = acc_num_reg;
        acc_den_next   = acc_den_reg;
        n_next         = n_reg;
        d_next         = d_reg;
        op_next        = op_reg;
        t_next         = t_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        q_next         = q_reg;
        r_next         = r_reg;
        cnt_next       = cnt_reg;
        phase_next     = phase_reg;
        out_valid_next = out_valid_reg;
        rnum_next      = rnum_reg;
        rden_next      = rden_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    op_next = op;
                    d_next  = den_in;
                    n_next  = (op == OP_SUB) ? (~num_in + 1'b1) : num_in;
                    case (op)
                        OP_LOAD:
                        begin
                            acc_num_next = num_in;
                            acc_den_next = den_in;
                            state_next   = ST_CHECK;
                        end
                        OP_ADD, OP_SUB:
                        begin
                            if (acc_num_reg == '0)
                            begin
                                acc_num_next = (op == OP_SUB) ? (~num_in + 1'b1) : num_in;
                                acc_den_next = den_in;
                                state_next   = ST_CHECK;
                            end
                            else if (acc_den_reg == den_in)
                            begin
                                acc_num_next = acc_num_reg +
                                    ((op == OP_SUB) ? (~num_in + 1'b1) : num_in);
                                state_next   = ST_CHECK;
                            end
                            else
                                state_next = ST_MUL1;
                        end
                        OP_MUL:
                        begin
                            n_next = den_in;
                            d_next = num_in;
                            state_next = ST_MUL1;
                        end
                        OP_DIV:  state_next = ST_MUL1;
                        default: state_next = ST_OUT;
                    endcase
                end
            end
            ST_MUL1:
            begin
                t_next     = mul_p;
                state_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                if (op_reg == OP_MUL || op_reg == OP_DIV)
                begin
                    acc_num_next = t_reg;
                    acc_den_next = mul_p;
                    state_next   = ST_CHECK;
                end
                else
                begin
                    t_next     = t_reg + mul_p;
                    state_next = ST_MUL3;
                end
            end
            ST_MUL3:
            begin
                acc_num_next = t_reg;
                acc_den_next = mul_p;
                state_next   = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (acc_num_reg == '0 || acc_den_reg == '0)
                begin
                    acc_num_next = '0;
                    acc_den_next = '0;
                    state_next   = ST_OUT;
                end
                else
                begin
                    a_next     = mag_num;
                    b_next     = mag_den;
                    q_next     = mag_num;
                    r_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_GCD;
                end
            end
            ST_GCD:
            begin
                if (b_reg == '0)
                begin
                    q_next     = mag_num;
                    r_next     = '0;
                    cnt_next   = '0;
                    state_next = ST_DIVN;
                end
                else
                begin
                    q_next = {q_reg[W-2:0], !r_sub[W]};
                    r_next = r_sub[W] ? r_sh : r_sub[W-1:0];
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CntWidth'(W - 1))
                    begin
                        a_next   = b_reg;
                        b_next   = r_sub[W] ? r_sh : r_sub[W-1:0];
                        q_next   = b_reg;
                        r_next   = '0;
                        cnt_next = '0;
                    end
                end
            end
            ST_DIVN, ST_DIVD:
            begin
                q_next   = {q_reg[W-2:0], !r_sub[W]};
                r_next   = r_sub[W] ? r_sh : r_sub[W-1:0];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CntWidth'(W - 1))
                begin
                    cnt_next = '0;
                    r_next   = '0;
                    if (state_reg == ST_DIVN)
                    begin
                        acc_num_next = acc_num_reg[W-1] ?
                            ~{q_reg[W-2:0], !r_sub[W]} + 1'b1 : {q_reg[W-2:0], !r_sub[W]};
                        q_next     = mag_den;
                        state_next = ST_DIVD;
                    end
                    else
                    begin
                        acc_den_next = acc_den_reg[W-1] ?
                            ~{q_reg[W-2:0], !r_sub[W]} + 1'b1 : {q_reg[W-2:0], !r_sub[W]};
                        state_next = ST_OUT;
                    end
                end
            end
            ST_OUT:
            begin
                rnum_next      = 32'(acc_num_reg);
                rden_next      = 32'(acc_den_reg);
                out_valid_next = 1'b1;
                phase_next     = ~phase_reg;
                state_next     = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            acc_num_reg   <= W'(1);
            acc_den_reg   <= W'(1);
            cnt_reg       <= '0;
            phase_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_num_reg   <= acc_num_next;
            acc_den_reg   <= acc_den_next;
            cnt_reg       <= cnt_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        d_reg    <= d_next;
        op_reg   <= op_next;
        t_reg    <= t_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        q_reg    <= q_next;
        r_reg    <= r_next;
        rnum_reg <= rnum_next;
        rden_reg <= rden_next;
    end

    `RAR_ASSERT_IMP(a_busy_not_ready, state_reg != ST_IDLE, !in_ready)
    `RAR_ASSERT_NXT(a_out_sets_valid, state_reg == ST_OUT, out_valid_reg && state_reg == ST_IDLE)
    `RAR_ASSERT_NXT(a_phase_on_out, state_reg == ST_OUT, phase_reg != $past(phase_reg))
    `RAR_ASSERT_IMP(a_zero_pair,
        out_valid_reg && (rnum_reg == '0 || rden_reg == '0), rnum_reg == rden_reg)
endmodule

>>> sim/rational_accumulator_reduce_top_test.sv
// Testbench for rational_accumulator_reduce_top: directed table, then random words.
// Predicts each result with its own fraction model; depends on rar_pkg and the block.
module rational_accumulator_reduce_top_test;
    import rar_pkg::*;

    localparam int WatchLimit = 40000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] op = 3'd0;
    logic signed [31:0] operand_num = 32'sd0;
    logic signed [31:0] operand_den = 32'sd0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] result_num;
    logic signed [31:0] result_den;

    typedef struct packed {
        logic [31:0] num;
        logic [31:0] den;
    } frac_t;

    typedef struct {
        logic [2:0] op;
        logic [31:0] num;
        logic [31:0] den;
        bit known;
        logic [31:0] want_num;
        logic [31:0] want_den;
    } row_t;

    frac_t fraction_queue[$];
    frac_t known_queue[$];
    bit known_flag_queue[$];
    logic [31:0] acc_num;
    logic [31:0] acc_den;
    int errors = 0;
    int idle_cycles = 0;
    bit stim_done = 1'b0;
    bit hold_long = 1'b0;

    rational_accumulator_reduce_top dut (.*);

    always #1 clk = ~clk;

    function automatic logic [31:0] mag(logic [31:0] x);
        return x[31] ? -x : x;
    endfunction

    function automatic logic [31:0] gcd_of(logic [31:0] a, logic [31:0] b);
        logic [31:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic logic [31:0] scale_down(logic [31:0] x, logic [31:0] g);
        logic [31:0] q;
        q = mag(x) / g;
        return x[31] ? -q : q;
    endfunction

    task automatic accumulate_sum(logic [31:0] n, logic [31:0] d);
        if (acc_num == 0)
        begin
            acc_num = n;
            acc_den = d;
        end
        else if (acc_den == d)
            acc_num = acc_num + n;
        else
        begin
            acc_num = acc_num * d + acc_den * n;
            acc_den = acc_den * d;
        end
    endtask

    task automatic predict_fraction(logic [2:0] o, logic [31:0] n, logic [31:0] d);
        logic [31:0] g;
        bit reduce;
        reduce = 1'b1;
        case (o)
            OP_LOAD: begin acc_num = n; acc_den = d; end
            OP_ADD:  accumulate_sum(n, d);
            OP_SUB:  accumulate_sum(-n, d);
            OP_MUL:  begin acc_num = acc_num * n; acc_den = acc_den * d; end
            OP_DIV:  begin acc_num = acc_num * d; acc_den = acc_den * n; end
            default: reduce = 1'b0;
        endcase
        if (reduce)
        begin
            if (acc_num == 0 || acc_den == 0)
            begin
                acc_num = 0;
                acc_den = 0;
            end
            else
            begin
                g = gcd_of(mag(acc_num), mag(acc_den));
                if (g == 0)
                    g = 1;
                acc_num = scale_down(acc_num, g);
                acc_den = scale_down(acc_den, g);
            end
        end
        fraction_queue.push_back('{acc_num, acc_den});
    endtask

    task automatic send_word(logic [2:0] o, logic [31:0] n, logic [31:0] d, bit known,
                             logic [31:0] wn, logic [31:0] wd);
        int gap;
        gap = $urandom_range(0, 7);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= o;
        operand_num <= n;
        operand_den <= d;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_fraction(o, n, d);
        known_flag_queue.push_back(known);
        known_queue.push_back('{wn, wd});
    endtask

    function automatic logic [31:0] rand_small();
        logic [31:0] v;
        v = $urandom_range(1, 60);
        if ($urandom_range(0, 1))
            v = -v;
        return v;
    endfunction

    function automatic logic [31:0] rand_any();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'd0;
            3, 4: return rand_small();
            default: return $urandom;
        endcase
    endfunction

    row_t rows[$];

    initial
    begin
        rows = '{
            '{OP_MUL,  32'd1, 32'd1, 1, 32'd1, 32'd1},
            '{OP_LOAD, 32'd3, 32'd4, 1, 32'd3, 32'd4},
            '{OP_LOAD, 32'd0, 32'd5, 1, 32'd0, 32'd0},
            '{OP_LOAD, 32'd7, 32'd0, 1, 32'd0, 32'd0},
            '{OP_ADD,  32'd2, 32'd3, 1, 32'd2, 32'd3},
            '{OP_ADD,  32'd5, 32'd3, 1, 32'd7, 32'd3},
            '{OP_ADD,  32'd1, 32'd2, 0, 32'd0, 32'd0},
            '{OP_SUB,  32'd1, 32'd6, 0, 32'd0, 32'd0},
            '{OP_MUL,  32'd2, 32'd5, 0, 32'd0, 32'd0},
            '{OP_DIV,  32'd3, 32'd7, 0, 32'd0, 32'd0},
            '{OP_LOAD, 32'd0, 32'd1, 1, 32'd0, 32'd0},
            '{OP_SUB,  32'd4, 32'd9, 1, -32'd4, 32'd9},
            '{3'd5,    32'd9, 32'd9, 1, -32'd4, 32'd9},
            '{3'd7,    32'hffff_ffff, 32'hffff_ffff, 1, -32'd4, 32'd9},
            '{OP_LOAD, 32'h8000_0000, 32'd1, 1, 32'h8000_0000, 32'd1},
            '{OP_LOAD, 32'h8000_0000, 32'h8000_0000, 1, 32'hffff_ffff, 32'hffff_ffff},
            '{OP_LOAD, 32'h7fff_ffff, -32'd1, 1, 32'h7fff_ffff, -32'd1},
            '{OP_MUL,  32'h7fff_ffff, 32'h8000_0000, 0, 32'd0, 32'd0},
            '{OP_LOAD, 32'd6, -32'd4, 1, 32'd3, -32'd2},
            '{OP_DIV,  32'd0, 32'd1, 1, 32'd0, 32'd0},
            '{3'd6,    32'd1, 32'd1, 1, 32'd0, 32'd0},
            '{OP_LOAD, 32'h8000_0000, 32'h7fff_ffff, 0, 32'd0, 32'd0},
            '{OP_ADD,  32'h7fff_ffff, 32'h8000_0000, 0, 32'd0, 32'd0}
        };
        acc_num = 32'd1;
        acc_den = 32'd1;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
            send_word(rows[i].op, rows[i].num, rows[i].den, rows[i].known,
                      rows[i].want_num, rows[i].want_den);
        for (int i = 0; i < 1500; i++)
        begin
            logic [2:0] o;
            logic [31:0] n, d;
            if (i == 300)
                hold_long <= 1'b1;
            if (i == 700)
            begin
                in_valid <= 1'b0;
                while (fraction_queue.size() != 0)
                    @(posedge clk);
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
            o = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            if ($urandom_range(0, 3) == 0)
            begin
                n = rand_any();
                d = rand_any();
            end
            else
            begin
                n = rand_small();
                d = ($urandom_range(0, 2) == 0) ? acc_den : rand_small();
                if ($urandom_range(0, 29) == 0)
                    d = 32'd0;
            end
            send_word(o, n, d, 1'b0, 32'd0, 32'd0);
        end
        in_valid <= 1'b0;
        stim_done = 1'b1;
    end

    initial
    begin
        @(posedge hold_long);
        repeat (300) @(posedge clk);
        hold_long <= 1'b0;
    end

    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 7);
            if (stall != 0 || hold_long)
                out_ready <= 1'b0;
            repeat (stall) @(posedge clk);
            while (hold_long)
                @(posedge clk);
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        frac_t want;
        frac_t typed;
        bit known;
        if (rst_n && out_valid && out_ready)
        begin
            if (fraction_queue.size() == 0)
            begin
                $error("result with nothing expected: %h/%h", result_num, result_den);
                errors++;
            end
            else
            begin
                want = fraction_queue.pop_front();
                known = known_flag_queue.pop_front();
                typed = known_queue.pop_front();
                if (known && typed != want)
                begin
                    $error("table row disagrees with prediction: %h/%h vs %h/%h",
                           typed.num, typed.den, want.num, want.den);
                    errors++;
                end
                if (result_num !== want.num)
                begin
                    $error("result_num expected %h actual %h", want.num, result_num);
                    errors++;
                end
                if (result_den !== want.den)
                begin
                    $error("result_den expected %h actual %h", want.den, result_den);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WatchLimit)
        begin
            $display("rational_accumulator_reduce_top_test: done, errors");
            $finish;
        end
    end

    initial
    begin
        wait (stim_done);
        while (fraction_queue.size() != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("rational_accumulator_reduce_top_test: done, clean");
        else
            $display("rational_accumulator_reduce_top_test: done, errors");
        $finish;
    end
endmodule

>>> rational_accumulator_reduce_top.f
+incdir+hdl
hdl/rar_pkg.sv
hdl/rational_accumulator_reduce_top.sv
sim/rational_accumulator_reduce_top_test.sv
